// ===== rtl/lbfs_pkg.sv =====
`default_nettype none

package lbfs_pkg;

    // Pattern codes
    localparam logic [3:0] PAT_IDLE        = 4'd0;
    localparam logic [3:0] PAT_PROCESSING  = 4'd1;
    localparam logic [3:0] PAT_FACE_LOW    = 4'd7;
    localparam logic [3:0] PAT_CHECKED_IN  = 4'd10;
    localparam logic [3:0] PAT_ON_TIME     = 4'd11;
    localparam logic [3:0] PAT_LATE        = 4'd12;
    localparam logic [3:0] PAT_CLOUD_FAIL  = 4'd13;
    localparam logic [3:0] PAT_INCIDENT    = 4'd14;
    localparam logic [3:0] PAT_INVALID     = 4'd15;

    // Configuration register indexes
    localparam logic [1:0] REG_DEFAULT_HOLD    = 2'd0;
    localparam logic [1:0] REG_PROCESSING_HOLD = 2'd1;
    localparam logic [1:0] REG_NOTICE_HOLD     = 2'd2;

    // Register reset values
    localparam logic [15:0] DEFAULT_HOLD_RST    = 16'd2000;
    localparam logic [15:0] PROCESSING_HOLD_RST = 16'd60000;
    localparam logic [15:0] NOTICE_HOLD_RST     = 16'd1000;

    // Beep timing in milliseconds
    localparam int SHORT_BEEP_MS  = 100;
    localparam int SECOND_BEEP_MS = 200;
    localparam int SECOND_END_MS  = 300;
    localparam int MID_BEEP_MS    = 500;
    localparam int LONG_BEEP_MS   = 1000;

    // Blink phase counter: runs 0 .. BLINK_PERIOD-1
    localparam int BLINK_PERIOD = 500;
    localparam int BLINK_ON     = 250;
    localparam int PHASE_W      = 9;

    // Which hold register a pattern uses
    typedef enum logic [1:0] {
        HOLD_DEFAULT    = 2'd0,
        HOLD_PROCESSING = 2'd1,
        HOLD_NOTICE     = 2'd2
    } hold_sel_t;

    // Compare results of the elapsed time against the beep windows
    typedef struct packed {
        logic lt_short;
        logic double_beep;
        logic lt_mid;
        logic lt_long;
        logic blink_on;
    } timing_t;

    // Drive levels for one tick
    typedef struct packed {
        logic red;
        logic green;
        logic buzz;
    } drive_t;

endpackage

`default_nettype wire

// ===== rtl/lbfs_pattern_decode.sv =====
`default_nettype none

module lbfs_pattern_decode (
    input  wire logic [3:0]          pattern,
    input  wire lbfs_pkg::timing_t   timing,
    output lbfs_pkg::drive_t         drive,
    output lbfs_pkg::hold_sel_t      hold_sel
);

    // Map the running pattern and the window flags onto the drives
    always_comb
    begin
        drive    = '0;
        hold_sel = lbfs_pkg::HOLD_DEFAULT;
        unique case (pattern)
            lbfs_pkg::PAT_IDLE,
            lbfs_pkg::PAT_INVALID:
            begin
                drive = '0;
            end
            lbfs_pkg::PAT_PROCESSING:
            begin
                drive.green = 1'b1;
                drive.buzz  = timing.lt_short;
                hold_sel    = lbfs_pkg::HOLD_PROCESSING;
            end
            lbfs_pkg::PAT_FACE_LOW:
            begin
                drive.red  = 1'b1;
                drive.buzz = timing.lt_long;
            end
            lbfs_pkg::PAT_CHECKED_IN:
            begin
                drive.green = timing.blink_on;
            end
            lbfs_pkg::PAT_ON_TIME:
            begin
                drive.green = 1'b1;
                drive.buzz  = timing.lt_short;
            end
            lbfs_pkg::PAT_LATE:
            begin
                drive.green = 1'b1;
                drive.buzz  = timing.double_beep;
            end
            lbfs_pkg::PAT_CLOUD_FAIL:
            begin
                drive.red  = 1'b1;
                drive.buzz = timing.lt_mid;
            end
            lbfs_pkg::PAT_INCIDENT:
            begin
                drive.green = 1'b1;
                drive.buzz  = timing.lt_short;
                hold_sel    = lbfs_pkg::HOLD_NOTICE;
            end
            default:
            begin
                // error kinds: red with a double beep
                drive.red  = 1'b1;
                drive.buzz = timing.double_beep;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/led_buzzer_feedback_sequencer.sv =====
// A transaction accepted into the input register is worked on from there and its result is
// loaded into the result register when the output moves. Throughput: one transaction per
// cycle while the output is not stalled; the pattern state updates in a single pass.
// Reset: asynchronous, active low; pattern idle, elapsed counter 0, hold registers
// at 2000 / 60000 / 1000 ms, both pipeline stages empty.
`default_nettype none

module led_buzzer_feedback_sequencer #(
    parameter int TIME_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        action,
    input  wire logic [3:0]  pattern_code,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             red_led,
    output logic             green_led,
    output logic             buzzer_on,
    output logic             active,
    output logic             finished
);

    localparam int CMP_W = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
    localparam logic [lbfs_pkg::PHASE_W-1:0] PHASE_LAST =
        lbfs_pkg::PHASE_W'(lbfs_pkg::BLINK_PERIOD - 1);

    // Hold registers
    logic [15:0] default_hold_reg;
    logic [15:0] processing_hold_reg;
    logic [15:0] notice_hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_hold_reg    <= lbfs_pkg::DEFAULT_HOLD_RST;
            processing_hold_reg <= lbfs_pkg::PROCESSING_HOLD_RST;
            notice_hold_reg     <= lbfs_pkg::NOTICE_HOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            // index beyond the list is dropped
            unique case (cfg_index)
                lbfs_pkg::REG_DEFAULT_HOLD:    default_hold_reg    <= cfg_data;
                lbfs_pkg::REG_PROCESSING_HOLD: processing_hold_reg <= cfg_data;
                lbfs_pkg::REG_NOTICE_HOLD:     notice_hold_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage
    logic       s1_valid_reg;
    logic       s1_action_reg;
    logic [3:0] s1_code_reg;
    logic       s1_move;

    assign s1_move  = !out_valid || !out_stall;
    assign in_stall = s1_valid_reg && !s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_action_reg <= action;
            s1_code_reg   <= pattern_code;
        end
    end

    // Pattern state
    logic [3:0]                    pattern_reg, pattern_next;
    logic [TIME_WIDTH-1:0]         elapsed_reg, elapsed_next;
    logic [lbfs_pkg::PHASE_W-1:0]  phase_reg, phase_next;

    // Window compares on the elapsed time
    logic [CMP_W-1:0]    e_ext;
    lbfs_pkg::timing_t   timing;
    lbfs_pkg::drive_t    drive;
    lbfs_pkg::hold_sel_t hold_sel;
    logic [15:0]         hold_ms;
    logic                hold_done;

    assign e_ext = CMP_W'(elapsed_reg);

    always_comb
    begin
        timing.lt_short    = e_ext < CMP_W'(lbfs_pkg::SHORT_BEEP_MS);
        timing.double_beep = timing.lt_short
                             || (e_ext >= CMP_W'(lbfs_pkg::SECOND_BEEP_MS)
                                 && e_ext < CMP_W'(lbfs_pkg::SECOND_END_MS));
        timing.lt_mid      = e_ext < CMP_W'(lbfs_pkg::MID_BEEP_MS);
        timing.lt_long     = e_ext < CMP_W'(lbfs_pkg::LONG_BEEP_MS);
        timing.blink_on    = phase_reg < lbfs_pkg::PHASE_W'(lbfs_pkg::BLINK_ON);
    end

    lbfs_pattern_decode u_decode (
        .pattern  (pattern_reg),
        .timing   (timing),
        .drive    (drive),
        .hold_sel (hold_sel)
    );

    always_comb
    begin
        unique case (hold_sel)
            lbfs_pkg::HOLD_PROCESSING: hold_ms = processing_hold_reg;
            lbfs_pkg::HOLD_NOTICE:     hold_ms = notice_hold_reg;
            default:                   hold_ms = default_hold_reg;
        endcase
    end

    assign hold_done = e_ext >= CMP_W'(hold_ms);

    // Next state and result for the transaction in the input stage
    logic res_red, res_green, res_buzz, res_active, res_fin;

    always_comb
    begin
        pattern_next = pattern_reg;
        elapsed_next = elapsed_reg;
        phase_next   = phase_reg;
        res_red      = 1'b0;
        res_green    = 1'b0;
        res_buzz     = 1'b0;
        res_fin      = 1'b0;
        priority if (s1_action_reg)
        begin
            // start: the invalid code falls back to idle
            pattern_next = (s1_code_reg == lbfs_pkg::PAT_INVALID) ?
                           lbfs_pkg::PAT_IDLE : s1_code_reg;
            elapsed_next = '0;
            phase_next   = '0;
        end
        else if (pattern_reg != lbfs_pkg::PAT_IDLE)
        begin
            if (hold_done)
            begin
                pattern_next = lbfs_pkg::PAT_IDLE;
                res_fin      = 1'b1;
            end
            else
            begin
                res_red   = drive.red;
                res_green = drive.green;
                res_buzz  = drive.buzz;
                // saturating count; blink phase follows it
                if (elapsed_reg != TIME_MAX)
                begin
                    elapsed_next = elapsed_reg + 1'b1;
                    phase_next   = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;
                end
            end
        end
        res_active = pattern_next != lbfs_pkg::PAT_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= lbfs_pkg::PAT_IDLE;
            elapsed_reg <= '0;
            phase_reg   <= '0;
        end
        else if (s1_valid_reg && s1_move)
        begin
            pattern_reg <= pattern_next;
            elapsed_reg <= elapsed_next;
            phase_reg   <= phase_next;
        end
    end

    // Result register
    logic out_valid_reg;
    logic red_reg, green_reg, buzz_reg, active_reg, fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_move)
        begin
            red_reg    <= res_red;
            green_reg  <= res_green;
            buzz_reg   <= res_buzz;
            active_reg <= res_active;
            fin_reg    <= res_fin;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_led   = red_reg;
    assign green_led = green_reg;
    assign buzzer_on = buzz_reg;
    assign active    = active_reg;
    assign finished  = fin_reg;

endmodule

`default_nettype wire
